@@ design/rc4d_pkg.sv @@
// Package for the RC4-drop256 stream cipher block.
// Holds the byte type, register map constants, codes and sequencer state encoding.
// No dependencies.
package rc4d_pkg;

  typedef logic [7:0] byte_t;

  // Key material: key bytes followed by IV bytes, packed into 64-bit registers
  localparam int KeyBytes  = 32;
  localparam int IvBytes   = 16;
  localparam int MatBytes  = KeyBytes + IvBytes;
  localparam int CfgW      = 64;
  localparam int NumRegs   = MatBytes / (CfgW / 8);
  localparam int CfgIdxW   = 3;
  localparam int MatIdxW   = 6;

  localparam logic [CfgIdxW-1:0] LastRegIdx = CfgIdxW'(NumRegs - 1);
  localparam logic [MatIdxW-1:0] MatLast    = MatIdxW'(MatBytes - 1);

  // Permutation table geometry
  localparam int    TableDepth = 256;
  localparam byte_t ByteMax    = 8'hFF;

  // Input action codes
  localparam logic ACT_REKEY = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Result status codes
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_NOT_KEYED = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,  // wait for an item
    S_INIT = 8'b0000_0010,  // write identity table
    S_KB   = 8'b0000_0100,  // key schedule: take S[k], read S[j]
    S_KC   = 8'b0000_1000,  // key schedule: write S[k]
    S_KD   = 8'b0001_0000,  // key schedule: write S[j], read S[k+1]
    S_GB   = 8'b0010_0000,  // generator: take S[i], read S[j]
    S_GC   = 8'b0100_0000,  // generator: write S[i], read S[a+b]
    S_GD   = 8'b1000_0000   // generator: write S[j], deliver byte
  } state_e;

endpackage

@@ design/rc4d_if.sv @@
// Stream channel interfaces of the RC4-drop256 cipher: input items and result items.
// Depends on rc4d_pkg for the byte type.
interface rc4d_in_if import rc4d_pkg::*;;
  logic  valid;
  logic  ready;
  logic  action;
  byte_t data_byte;
  logic  last;

  modport source (output valid, output action, output data_byte, output last, input ready);
  modport sink   (input valid, input action, input data_byte, input last, output ready);
endinterface

interface rc4d_out_if import rc4d_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t result_byte;
  logic  status;
  logic  last_res;

  modport source (output valid, output result_byte, output status, output last_res,
                  input ready);
  modport sink   (input valid, input result_byte, input status, input last_res,
                  output ready);
endinterface

@@ design/rc4_drop256_stream_cipher.sv @@
// RC4-drop256 stream cipher, top level. Uses rc4d_pkg, rc4d_if and rc4d_ram.
// Data item: the generator steps through S_GB, S_GC and S_GD (table read-swap-read) and
//   registers the result in S_GD once the output is free; the next item is taken in the cycle the result is loaded.
// Data item before any rekey: result in the cycle after the transfer.
// Rekey: identity fill, key schedule over all 256 table entries, then a 256-byte discard run.
// Reset clears indices, the configuration registers and the keyed flag; the table is rebuilt by each rekey.
module rc4_drop256_stream_cipher import rc4d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  rc4d_in_if.sink            in_if,
  rc4d_out_if.source         out_if
);

  state_e            state_q, state_d;
  logic [CfgW-1:0]   cfg_q [NumRegs];
  byte_t             cnt_q, cnt_d;
  byte_t             i_q, i_d;
  byte_t             j_q, j_d;
  byte_t             a_q, a_d;
  byte_t             t_q, t_d;
  logic [MatIdxW-1:0] m_q, m_d;
  logic              drop_q, drop_d;
  logic              keyed_q, keyed_d;
  byte_t             data_q, data_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  byte_t             out_res_q, out_res_d;
  logic              out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic              byp_q;
  byte_t             byp_data_q;

  logic  ram_we, ram_re;
  byte_t ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  byte_t rd_data, mat_byte, ks, jn, sum_ab;
  logic  out_free, in_ready, in_acc;

  // Permutation table
  rc4d_ram #(.Width(8), .Depth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Forward a write that collides with the read issued in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (ram_re) begin
      byp_q <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      byp_data_q <= ram_wdata;
    end
  end

  assign rd_data = byp_q ? byp_data_q : ram_rdata;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= LastRegIdx)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Key material byte m: register m/8, byte m%8
  assign mat_byte = cfg_q[m_q[5:3]][{m_q[2:0], 3'b000} +: 8];

  // Keystream byte: the later write of S[j] wins over the value read at a+b
  assign ks = (t_q == j_q) ? a_q : rd_data;

  assign jn     = j_q + rd_data + mat_byte;
  assign sum_ab = a_q + rd_data;

  assign out_free = !out_valid_q || out_if.ready;
  assign in_ready = out_free && ((state_q == S_IDLE) || ((state_q == S_GD) && !drop_q));
  assign in_acc   = in_if.valid && in_ready;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    i_d          = i_q;
    j_d          = j_q;
    a_d          = a_q;
    t_d          = t_q;
    m_d          = m_q;
    drop_d       = drop_q;
    keyed_d      = keyed_q;
    data_d       = data_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_res_d    = out_res_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = cnt_q;
        cnt_d     = cnt_q + 8'd1;
        if (cnt_q == ByteMax) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          j_d       = '0;
          m_d       = '0;
          state_d   = S_KB;
        end
      end
      S_KB: begin
        a_d       = rd_data;
        j_d       = jn;
        ram_re    = 1'b1;
        ram_raddr = jn;
        state_d   = S_KC;
      end
      S_KC: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = rd_data;
        state_d   = S_KD;
      end
      S_KD: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
        ram_re    = 1'b1;
        cnt_d     = cnt_q + 8'd1;
        if (cnt_q == ByteMax) begin
          // schedule done: set i to 1, clear j and start the discard run
          i_d       = 8'd1;
          j_d       = '0;
          ram_raddr = 8'd1;
          drop_d    = 1'b1;
          state_d   = S_GB;
        end else begin
          m_d       = (m_q == MatLast) ? '0 : m_q + 6'd1;
          ram_raddr = cnt_q + 8'd1;
          state_d   = S_KB;
        end
      end
      S_GB: begin
        a_d       = rd_data;
        j_d       = j_q + rd_data;
        ram_re    = 1'b1;
        ram_raddr = j_q + rd_data;
        state_d   = S_GC;
      end
      S_GC: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = rd_data;
        ram_re    = 1'b1;
        ram_raddr = sum_ab;
        t_d       = sum_ab;
        state_d   = S_GD;
      end
      S_GD: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
        if (drop_q) begin
          if (cnt_q == ByteMax) begin
            // discard run done: deliver the rekey result
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_res_d    = '0;
              out_status_d = STAT_OK;
              out_last_d   = last_q;
              keyed_d      = 1'b1;
              drop_d       = 1'b0;
              state_d      = S_IDLE;
            end
          end else begin
            cnt_d     = cnt_q + 8'd1;
            ram_re    = 1'b1;
            ram_raddr = i_q + 8'd1;
            i_d       = i_q + 8'd1;
            state_d   = S_GB;
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_res_d    = data_q ^ ks;
          out_status_d = STAT_OK;
          out_last_d   = last_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Take a new item
    if (in_acc) begin
      data_d = in_if.data_byte;
      last_d = in_if.last;
      if (in_if.action == ACT_REKEY) begin
        cnt_d   = '0;
        state_d = S_INIT;
      end else if (!keyed_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = '0;
        out_status_d = STAT_NOT_KEYED;
        out_last_d   = in_if.last;
      end else begin
        ram_re    = 1'b1;
        ram_raddr = i_q + 8'd1;
        i_d       = i_q + 8'd1;
        state_d   = S_GB;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      drop_q      <= 1'b0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      m_q         <= m_d;
      drop_q      <= drop_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    t_q          <= t_d;
    data_q       <= data_d;
    last_q       <= last_d;
    out_res_q    <= out_res_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  // Ports
  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_q;
  assign out_if.result_byte = out_res_q;
  assign out_if.status      = out_status_q;
  assign out_if.last_res    = out_last_q;

  // Once keyed, the block stays keyed
  a_keyed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_q |=> keyed_q)
    else $error("keyed flag dropped");

  // A keyed data transfer starts the generator
  a_data_starts_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_if.action == ACT_DATA) && keyed_q) |=> (state_q == S_GB))
    else $error("keyed data item did not enter the generator");

  // Data before any rekey answers at once with the not-keyed status
  a_unkeyed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_if.action == ACT_DATA) && !keyed_q)
      |=> (out_valid_q && (out_status_q == STAT_NOT_KEYED) && (state_q == S_IDLE)))
    else $error("unkeyed data item mishandled");

  // End of the key schedule starts the discard run from i = 1
  a_ksa_to_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_KD) && (cnt_q == ByteMax))
      |=> ((state_q == S_GB) && drop_q && (i_q == 8'd1) && (j_q == 8'd0)))
    else $error("key schedule did not hand over to the discard run");

endmodule

@@ design/rc4d_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rc4d_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sim/rc4_drop256_stream_cipher_tb.sv @@
// Testbench for the RC4-drop256 stream cipher: directed and random cipher traffic with
// key changes, checked against an in-bench keystream predictor. Uses rc4d_pkg and rc4d_if.
`timescale 1ns / 1ps

module rc4_drop256_stream_cipher_tb;
  import rc4d_pkg::*;

  typedef struct packed {
    logic  action;
    byte_t data;
    logic  last;
  } item_t;

  typedef struct packed {
    byte_t result_byte;
    logic  status;
    logic  last_res;
  } res_t;

  typedef enum int {KEY_ZERO, KEY_ONES, KEY_ALT, KEY_RAND} key_kind_e;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  rc4d_in_if  in_if ();
  rc4d_out_if out_if ();

  rc4_drop256_stream_cipher u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // Predictor state: register copy, permutation and indices
  logic [CfgW-1:0] key_regs [NumRegs];
  byte_t           ks_table [TableDepth];
  byte_t           ks_i;
  byte_t           ks_j;
  logic            ks_keyed;

  item_t byte_item_q [$];
  res_t  cipher_res_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          n_queued   = 0;
  int          n_accepted = 0;
  int          n_rekey    = 0;
  int          n_data     = 0;
  int          n_checked  = 0;
  int          err_cnt    = 0;

  logic        stall_arm = 1'b0;
  logic        stall_done;
  int unsigned stall_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Keystream predictor
  function automatic void cipher_reset_state();
    for (int k = 0; k < TableDepth; k++) ks_table[k] = byte_t'(k);
    ks_i     = '0;
    ks_j     = '0;
    ks_keyed = 1'b0;
  endfunction

  function automatic byte_t keystream_next();
    byte_t a;
    byte_t b;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + ks_table[ks_i];
    a = ks_table[ks_i];
    b = ks_table[ks_j];
    ks_table[ks_i] = b;
    ks_table[ks_j] = a;
    return ks_table[byte_t'(a + b)];
  endfunction

  function automatic void schedule_key();
    byte_t mat [MatBytes];
    byte_t j;
    byte_t t;
    for (int k = 0; k < MatBytes; k++) mat[k] = key_regs[k / 8][8 * (k % 8) +: 8];
    for (int k = 0; k < TableDepth; k++) ks_table[k] = byte_t'(k);
    j = '0;
    for (int k = 0; k < TableDepth; k++) begin
      j = j + ks_table[k] + mat[k % MatBytes];
      t = ks_table[k];
      ks_table[k] = ks_table[j];
      ks_table[j] = t;
    end
    ks_i     = '0;
    ks_j     = '0;
    ks_keyed = 1'b1;
    // drop the first table-length of keystream
    repeat (TableDepth) void'(keystream_next());
  endfunction

  function automatic res_t cipher_predict(item_t it);
    res_t r;
    r.result_byte = '0;
    r.status      = STAT_OK;
    r.last_res    = it.last;
    if (it.action == ACT_REKEY) begin
      schedule_key();
    end else if (!ks_keyed) begin
      r.status = STAT_NOT_KEYED;
    end else begin
      r.result_byte = it.data ^ keystream_next();
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    err_cnt++;
    $display("%0t: mismatch on %s, want %0h got %0h (result %0d)", $realtime, what, want, got,
             n_checked);
  endtask

  // Driver: offer queued items, hold each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    item_t nxt;
    logic  held;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.action    <= ACT_DATA;
      in_if.data_byte <= '0;
      in_if.last      <= 1'b0;
      cipher_reset_state();
    end else begin
      held = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        nxt.action = in_if.action;
        nxt.data   = in_if.data_byte;
        nxt.last   = in_if.last;
        cipher_res_q.push_back(cipher_predict(nxt));
        if (nxt.action == ACT_REKEY) n_rekey++;
        else n_data++;
        n_accepted++;
        held = 1'b0;
      end
      if (!held) begin
        if (byte_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_item_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.action    <= nxt.action;
          in_if.data_byte <= nxt.data;
          in_if.last      <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the sequence
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left <= 300;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : monitor_p
    res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cipher_res_q.size() == 0) begin
          report_mismatch("result with none pending", 8'h00, out_if.result_byte);
        end else begin
          want = cipher_res_q.pop_front();
          if (out_if.result_byte !== want.result_byte)
            report_mismatch("result_byte", want.result_byte, out_if.result_byte);
          if (out_if.status !== want.status)
            report_mismatch("status", 8'(want.status), 8'(out_if.status));
          if (out_if.last_res !== want.last_res)
            report_mismatch("last_res", 8'(want.last_res), 8'(out_if.last_res));
        end
        n_checked++;
      end
      out_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_item(logic action, byte_t data, logic last);
    item_t it;
    it.action = action;
    it.data   = data;
    it.last   = last;
    byte_item_q.push_back(it);
    n_queued++;
  endtask

  // Wait until every queued item has transferred and every result has arrived
  task automatic drain();
    while (n_accepted != n_queued || cipher_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx < NumRegs) key_regs[idx] = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(key_kind_e kind);
    logic [CfgW-1:0] val;
    for (int r = 0; r < NumRegs; r++) begin
      case (kind)
        KEY_ZERO: val = '0;
        KEY_ONES: val = '1;
        KEY_ALT:  val = {(CfgW / 8){(r % 2 == 0) ? 8'h55 : 8'hAA}};
        default:  val = {$urandom, $urandom};
      endcase
      write_reg(CfgIdxW'(r), val);
    end
  endtask

  task automatic random_items(int count, bit rekey_first);
    for (int k = 0; k < count; k++) begin
      if (rekey_first && k == 0)
        queue_item(ACT_REKEY, byte_t'($urandom), 1'($urandom_range(1)));
      else
        queue_item(($urandom_range(99) < 4) ? ACT_REKEY : ACT_DATA, byte_t'($urandom),
                   $urandom_range(7) == 0);
    end
  endtask

  // Sequence
  initial begin
    rst_ni = 1'b0;
    for (int r = 0; r < NumRegs; r++) key_regs[r] = '0;
    send_idle_pct = 19;
    recv_idle_pct = 82;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Data before any rekey: not keyed, zero byte, state untouched
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, ByteMax, 1'b1);
    queue_item(ACT_DATA, 8'h5A, 1'b0);
    // Rekey from the reset registers, then stream the extremes
    queue_item(ACT_REKEY, ByteMax, 1'b1);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, ByteMax, 1'b1);
    queue_item(ACT_DATA, 8'h55, 1'b0);
    queue_item(ACT_DATA, 8'hAA, 1'b1);
    // Back-to-back rekeys restart from the identity table
    queue_item(ACT_REKEY, 8'h00, 1'b0);
    queue_item(ACT_REKEY, 8'hA5, 1'b1);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    drain();

    // New key is not used until the next rekey
    load_key(KEY_ONES);
    queue_item(ACT_DATA, ByteMax, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b1);
    queue_item(ACT_REKEY, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, ByteMax, 1'b1);
    queue_item(ACT_DATA, 8'h12, 1'b0);
    drain();
    // Writes past the register map change nothing
    for (int r = NumRegs; r < (1 << CfgIdxW); r++) write_reg(CfgIdxW'(r), '1);
    queue_item(ACT_REKEY, 8'h3C, 1'b1);
    queue_item(ACT_DATA, 8'h80, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b1);
    drain();

    // Random phases across key settings and idle patterns
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 19;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0:       load_key(KEY_ZERO);
        1, 7:    load_key(KEY_ONES);
        3:       load_key(KEY_ALT);
        default: load_key(KEY_RAND);
      endcase
      if (p == 4)
        for (int r = NumRegs; r < (1 << CfgIdxW); r++) write_reg(CfgIdxW'(r), {$urandom, $urandom});
      if (p == 6) begin
        @(posedge clk_i);
        stall_arm <= 1'b1;
      end
      // phases 4 and 6 keep the old keystream running across the key change
      random_items(88, p != 4 && p != 6);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (cipher_res_q.size() != 0) report_mismatch("results never delivered", 8'h00, 8'h00);
    $display("Covered %0d rekeys and %0d data bytes over four key patterns and three idle mixes,",
             n_rekey, n_data);
    $display("with one long receiver hold-off; %0d results checked, %0d mismatches.",
             n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout: %0d of %0d items accepted, %0d results pending", n_accepted, n_queued,
             cipher_res_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
